/* design/plx_pkg.sv */
`timescale 1ns / 1ps
package plx_pkg;

    localparam int CharW   = 8;
    localparam int KindW   = 3;
    localparam int CodeW   = 3;
    localparam int ParamW  = 3;
    localparam int MaxRes  = 4;
    localparam int ResIdxW = 2;
    localparam int ResCntW = 3;

    localparam logic [KindW-1:0] KIND_CMD    = 3'd0;
    localparam logic [KindW-1:0] KIND_PCHAR  = 3'd1;
    localparam logic [KindW-1:0] KIND_PEND   = 3'd2;
    localparam logic [KindW-1:0] KIND_ERROR  = 3'd3;
    localparam logic [KindW-1:0] KIND_DONE   = 3'd4;

    localparam logic [CodeW-1:0] ERR_NONE      = 3'd0;
    localparam logic [CodeW-1:0] ERR_BAD_CMD   = 3'd1;
    localparam logic [CodeW-1:0] ERR_MINUS     = 3'd2;
    localparam logic [CodeW-1:0] ERR_POINT     = 3'd3;
    localparam logic [CodeW-1:0] ERR_MISSING   = 3'd4;
    localparam logic [CodeW-1:0] ERR_TOO_FEW   = 3'd5;

    localparam logic [CharW-1:0] CH_MINUS = 8'h2d;
    localparam logic [CharW-1:0] CH_POINT = 8'h2e;
    localparam logic [CharW-1:0] CH_ZERO  = 8'h30;
    localparam logic [CharW-1:0] CH_NINE  = 8'h39;
    localparam logic [CharW-1:0] CH_NUL   = 8'h00;

    typedef struct packed {
        logic [KindW-1:0] kind;
        logic [CharW-1:0] char_out;
        logic [CodeW-1:0] error_code;
        logic             last_result;
    } t_result;

    typedef t_result [MaxRes-1:0] t_result_set;

    typedef struct packed {
        logic              command_active;
        logic [ParamW-1:0] params_left;
        logic              number_started;
        logic              point_seen;
        logic              error_latched;
    } t_state;

    typedef struct packed {
        logic              found;
        logic [ParamW-1:0] count;
    } t_cmd_info;

    function automatic logic is_sep(input logic [CharW-1:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0a) || (c == 8'h0b)
            || (c == 8'h0c) || (c == 8'h0d) || (c == 8'h2c);
    endfunction

    function automatic t_cmd_info cmd_lookup(input logic [CharW-1:0] c);
        t_cmd_info info;
        info.found = 1'b1;
        case (c)
            "M", "m", "L", "l", "T", "t": info.count = 3'd2;
            "Z", "z":                     info.count = 3'd0;
            "H", "h", "V", "v":           info.count = 3'd1;
            "C", "c":                     info.count = 3'd6;
            "S", "s", "Q", "q":           info.count = 3'd4;
            "A", "a":                     info.count = 3'd7;
            default: begin
                info.found = 1'b0;
                info.count = 3'd0;
            end
        endcase
        return info;
    endfunction

    function automatic t_result make_res(input logic [KindW-1:0] kind,
                                         input logic [CharW-1:0] ch,
                                         input logic [CodeW-1:0] code);
        t_result r;
        r.kind        = kind;
        r.char_out    = ch;
        r.error_code  = code;
        r.last_result = 1'b0;
        return r;
    endfunction

endpackage

/* design/svg_path_data_lexer_top.sv */
`timescale 1ns / 1ps
// a character is registered in the input stage, its results in the result buffer
// throughput: one character per cycle while the output is ready and each
// yields at most one result; one with n results holds the buffer until all n leave
// reset: synchronous active-low reset clears the lexer state, input stage and
// result buffer; no clearing pass is needed
module svg_path_data_lexer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] char_code
    input  logic        i_s_tlast,   // end_of_string
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [7:0] char_out, [10:8] error_code, rest zero
    output logic [2:0]  o_m_tuser,   // kind
    output logic        o_m_tlast    // last_result
);

    logic                        r_in_valid;
    logic [plx_pkg::CharW-1:0]   r_char;
    logic                        r_eos;
    plx_pkg::t_state             r_state;
    plx_pkg::t_state             n_state;
    plx_pkg::t_result_set        step_res;
    logic [plx_pkg::ResCntW-1:0] step_cnt;
    plx_pkg::t_result            out_res;
    logic                        buf_free;
    logic                        consume;

    assign consume    = r_in_valid && buf_free;
    assign o_s_tready = !r_in_valid || consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= '0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (consume) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_char <= i_s_tdata;
            r_eos  <= i_s_tlast;
        end
    end

    plx_step u_step (
        .i_char  (r_char),
        .i_eos   (r_eos),
        .i_state (r_state),
        .o_state (n_state),
        .o_res   (step_res),
        .o_cnt   (step_cnt)
    );

    plx_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (consume),
        .i_res   (step_res),
        .i_cnt   (step_cnt),
        .o_free  (buf_free),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_res   (out_res)
    );

    assign o_m_tdata = {5'd0, out_res.error_code, out_res.char_out};
    assign o_m_tuser = out_res.kind;
    assign o_m_tlast = out_res.last_result;

endmodule

/* design/plx_step.sv */
`timescale 1ns / 1ps
module plx_step (
    input  logic [plx_pkg::CharW-1:0]   i_char,
    input  logic                        i_eos,
    input  plx_pkg::t_state             i_state,
    output plx_pkg::t_state             o_state,
    output plx_pkg::t_result_set        o_res,
    output logic [plx_pkg::ResCntW-1:0] o_cnt
);

    plx_pkg::t_result_set        res;
    logic [plx_pkg::ResCntW-1:0] cnt;
    plx_pkg::t_state             st;
    plx_pkg::t_cmd_info          info;
    logic                        sep;
    logic                        digit;
    logic                        redo;

    always_comb begin
        res   = '0;
        cnt   = '0;
        st    = i_state;
        info  = plx_pkg::cmd_lookup(i_char);
        sep   = plx_pkg::is_sep(i_char);
        digit = (i_char >= plx_pkg::CH_ZERO) && (i_char <= plx_pkg::CH_NINE);
        redo  = 1'b0;

        // first pass
        if (!st.error_latched) begin
            if (!st.command_active) begin
                if (!sep) begin
                    if (!info.found) begin
                        res[cnt[plx_pkg::ResIdxW-1:0]] = plx_pkg::make_res(
                            plx_pkg::KIND_ERROR, plx_pkg::CH_NUL, plx_pkg::ERR_BAD_CMD);
                        cnt = cnt + 1'b1;
                        st.error_latched = 1'b1;
                    end else begin
                        res[cnt[plx_pkg::ResIdxW-1:0]] = plx_pkg::make_res(
                            plx_pkg::KIND_CMD, i_char, plx_pkg::ERR_NONE);
                        cnt = cnt + 1'b1;
                        st.params_left    = info.count;
                        st.command_active = (info.count != '0);
                        st.number_started = 1'b0;
                        st.point_seen     = 1'b0;
                    end
                end
            end else if (i_char == plx_pkg::CH_MINUS) begin
                if (st.number_started) begin
                    res[cnt[plx_pkg::ResIdxW-1:0]] = plx_pkg::make_res(
                        plx_pkg::KIND_ERROR, plx_pkg::CH_NUL, plx_pkg::ERR_MINUS);
                    cnt = cnt + 1'b1;
                    st.error_latched = 1'b1;
                end else begin
                    res[cnt[plx_pkg::ResIdxW-1:0]] = plx_pkg::make_res(
                        plx_pkg::KIND_PCHAR, i_char, plx_pkg::ERR_NONE);
                    cnt = cnt + 1'b1;
                    st.number_started = 1'b1;
                end
            end else if (i_char == plx_pkg::CH_POINT) begin
                if (st.point_seen) begin
                    res[cnt[plx_pkg::ResIdxW-1:0]] = plx_pkg::make_res(
                        plx_pkg::KIND_ERROR, plx_pkg::CH_NUL, plx_pkg::ERR_POINT);
                    cnt = cnt + 1'b1;
                    st.error_latched = 1'b1;
                end else begin
                    // leading point gets a zero in front
                    if (!st.number_started) begin
                        res[cnt[plx_pkg::ResIdxW-1:0]] = plx_pkg::make_res(
                            plx_pkg::KIND_PCHAR, plx_pkg::CH_ZERO, plx_pkg::ERR_NONE);
                        cnt = cnt + 1'b1;
                    end
                    res[cnt[plx_pkg::ResIdxW-1:0]] = plx_pkg::make_res(
                        plx_pkg::KIND_PCHAR, i_char, plx_pkg::ERR_NONE);
                    cnt = cnt + 1'b1;
                    st.number_started = 1'b1;
                    st.point_seen     = 1'b1;
                end
            end else if (digit) begin
                res[cnt[plx_pkg::ResIdxW-1:0]] = plx_pkg::make_res(
                    plx_pkg::KIND_PCHAR, i_char, plx_pkg::ERR_NONE);
                cnt = cnt + 1'b1;
                st.number_started = 1'b1;
            end else if (st.number_started) begin
                res[cnt[plx_pkg::ResIdxW-1:0]] = plx_pkg::make_res(
                    plx_pkg::KIND_PEND, plx_pkg::CH_NUL, plx_pkg::ERR_NONE);
                cnt = cnt + 1'b1;
                st.number_started = 1'b0;
                st.point_seen     = 1'b0;
                st.params_left    = st.params_left - 1'b1;
                if (st.params_left == '0) begin
                    st.command_active = 1'b0;
                end
                redo = !sep;
            end else if (!sep) begin
                res[cnt[plx_pkg::ResIdxW-1:0]] = plx_pkg::make_res(
                    plx_pkg::KIND_ERROR, plx_pkg::CH_NUL, plx_pkg::ERR_MISSING);
                cnt = cnt + 1'b1;
                st.error_latched = 1'b1;
            end
        end

        // second pass: char that ended a number is a command, else a missing-parameter or bad-command error
        if (redo) begin
            if (!st.command_active && info.found) begin
                res[cnt[plx_pkg::ResIdxW-1:0]] = plx_pkg::make_res(
                    plx_pkg::KIND_CMD, i_char, plx_pkg::ERR_NONE);
                cnt = cnt + 1'b1;
                st.params_left    = info.count;
                st.command_active = (info.count != '0);
            end else begin
                res[cnt[plx_pkg::ResIdxW-1:0]] = plx_pkg::make_res(
                    plx_pkg::KIND_ERROR, plx_pkg::CH_NUL,
                    st.command_active ? plx_pkg::ERR_MISSING : plx_pkg::ERR_BAD_CMD);
                cnt = cnt + 1'b1;
                st.error_latched = 1'b1;
            end
        end

        if (i_eos) begin
            if (st.error_latched) begin
                res[cnt[plx_pkg::ResIdxW-1:0]] = plx_pkg::make_res(
                    plx_pkg::KIND_ERROR, plx_pkg::CH_NUL, plx_pkg::ERR_NONE);
                cnt = cnt + 1'b1;
            end else begin
                if (st.number_started) begin
                    res[cnt[plx_pkg::ResIdxW-1:0]] = plx_pkg::make_res(
                        plx_pkg::KIND_PEND, plx_pkg::CH_NUL, plx_pkg::ERR_NONE);
                    cnt = cnt + 1'b1;
                    st.params_left = st.params_left - 1'b1;
                    if (st.params_left == '0) begin
                        st.command_active = 1'b0;
                    end
                end
                if (st.command_active && (st.params_left != '0)) begin
                    res[cnt[plx_pkg::ResIdxW-1:0]] = plx_pkg::make_res(
                        plx_pkg::KIND_ERROR, plx_pkg::CH_NUL, plx_pkg::ERR_TOO_FEW);
                end else begin
                    res[cnt[plx_pkg::ResIdxW-1:0]] = plx_pkg::make_res(
                        plx_pkg::KIND_DONE, plx_pkg::CH_NUL, plx_pkg::ERR_NONE);
                end
                cnt = cnt + 1'b1;
            end
            st = '0;
        end

        if (cnt != '0) begin
            res[cnt[plx_pkg::ResIdxW-1:0] - 1'b1].last_result = 1'b1;
        end
    end

    assign o_state = st;
    assign o_res   = res;
    assign o_cnt   = cnt;

endmodule

/* design/plx_outbuf.sv */
`timescale 1ns / 1ps
module plx_outbuf (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  plx_pkg::t_result_set        i_res,
    input  logic [plx_pkg::ResCntW-1:0] i_cnt,
    output logic                        o_free,
    output logic                        o_valid,
    input  logic                        i_ready,
    output plx_pkg::t_result            o_res
);

    plx_pkg::t_result_set        r_res;
    logic [plx_pkg::ResCntW-1:0] r_cnt;
    logic [plx_pkg::ResIdxW-1:0] r_idx;
    logic                        at_last;

    assign at_last = ({1'b0, r_idx} + 1'b1) == r_cnt;
    assign o_valid = (r_cnt != '0);
    assign o_res   = r_res[r_idx];
    // empty, or the final entry leaves this cycle
    assign o_free  = (r_cnt == '0) || (at_last && i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else if (i_load) begin
            r_cnt <= i_cnt;
            r_idx <= '0;
        end else if (o_valid && i_ready) begin
            if (at_last) begin
                r_cnt <= '0;
                r_idx <= '0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule
